// ----- hdl/tda_pkg.sv -----
// Shared widths, constants and types of the track direction angle pipeline.
`default_nettype none

package tda_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int ANGLE_WIDTH = 16;
  localparam int TAG_WIDTH   = 16;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int GUARD_BITS  = 56 - COORD_WIDTH;
  localparam int DW          = 64;
  localparam int ITERS       = 30;
  localparam int ACC_W       = 36;
  localparam int ROUND_SHIFT = 32 - ANGLE_WIDTH;
  localparam int PF_W        = ACC_W - ROUND_SHIFT;
  localparam int Q_OUT       = 1 << (ANGLE_WIDTH - 2);

  localparam logic [31:0] INV_GAIN = 32'd2608131497;
  localparam logic signed [ACC_W-1:0] QUARTER_TURN = ACC_W'(64'd1 << 30);
  localparam logic signed [ACC_W-1:0] HALF_TURN    = ACC_W'(64'd1 << 31);
  localparam logic [31:0] ROUND_HALF = 32'(64'd1 << (31 - ANGLE_WIDTH));

  typedef logic signed [DW-1:0]    vec_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // Data that rides alongside the CORDIC datapath.
  typedef struct packed {
    logic [TAG_WIDTH-1:0]          tag;
    logic signed [DIFF_WIDTH-1:0]  dz;
    logic                          tzero;
    logic [ANGLE_WIDTH-1:0]        azim;
  } side_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic acc_t atan_step(input int unsigned i);
    acc_t v;
    case (i)
      0:  v = ACC_W'(536870912);
      1:  v = ACC_W'(316933406);
      2:  v = ACC_W'(167458907);
      3:  v = ACC_W'(85004756);
      4:  v = ACC_W'(42667331);
      5:  v = ACC_W'(21354465);
      6:  v = ACC_W'(10679838);
      7:  v = ACC_W'(5340245);
      8:  v = ACC_W'(2670163);
      9:  v = ACC_W'(1335087);
      10: v = ACC_W'(667544);
      11: v = ACC_W'(333772);
      12: v = ACC_W'(166886);
      13: v = ACC_W'(83443);
      14: v = ACC_W'(41722);
      15: v = ACC_W'(20861);
      16: v = ACC_W'(10430);
      17: v = ACC_W'(5215);
      18: v = ACC_W'(2608);
      19: v = ACC_W'(1304);
      20: v = ACC_W'(652);
      21: v = ACC_W'(326);
      22: v = ACC_W'(163);
      23: v = ACC_W'(81);
      24: v = ACC_W'(41);
      25: v = ACC_W'(20);
      26: v = ACC_W'(10);
      27: v = ACC_W'(5);
      28: v = ACC_W'(3);
      29: v = ACC_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tda_cordic.sv -----
// Pipelined vectoring CORDIC: a quadrant pre-rotation stage and one stage per iteration.
`default_nettype none

module tda_cordic
  import tda_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire vec_t  in_x,
  input  wire vec_t  in_y,
  input  wire side_t in_side,
  output logic       out_valid,
  output vec_t       out_x,
  output acc_t       out_ang,
  output side_t      out_side
);

  logic  valid_r [0:ITERS];
  vec_t  x_r     [0:ITERS];
  vec_t  y_r     [0:ITERS];
  acc_t  ang_r   [0:ITERS];
  side_t side_r  [0:ITERS];

  vec_t x0_nxt, y0_nxt;
  acc_t a0_nxt;

  // Vectors in the left half plane are turned by a quarter turn first.
  always_comb begin
    x0_nxt = in_x;
    y0_nxt = in_y;
    a0_nxt = '0;
    if (in_x[DW-1]) begin
      if (!in_y[DW-1]) begin
        x0_nxt = in_y;
        y0_nxt = -in_x;
        a0_nxt = QUARTER_TURN;
      end else begin
        x0_nxt = -in_y;
        y0_nxt = in_x;
        a0_nxt = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      ang_r[0]  <= a0_nxt;
      side_r[0] <= in_side;
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    vec_t xs, ys, x_nxt, y_nxt;
    acc_t a_nxt;

    always_comb begin
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
      if (!y_r[i][DW-1]) begin
        x_nxt = x_r[i] + ys;
        y_nxt = y_r[i] - xs;
        a_nxt = ang_r[i] + atan_step(i);
      end else begin
        x_nxt = x_r[i] - ys;
        y_nxt = y_r[i] + xs;
        a_nxt = ang_r[i] - atan_step(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i+1] <= 1'b0;
      end else if (en) begin
        valid_r[i+1] <= valid_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        ang_r[i+1]  <= a_nxt;
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_valid = valid_r[ITERS];
  assign out_x     = x_r[ITERS];
  assign out_ang   = ang_r[ITERS];
  assign out_side  = side_r[ITERS];

endmodule

`default_nettype wire

// ----- hdl/tda_gain.sv -----
// Azimuth rounding and CORDIC gain removal from the magnitude, two stages.
`default_nettype none

module tda_gain
  import tda_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire vec_t  in_mag,
  input  wire acc_t  in_ang,
  input  wire side_t in_side,
  output logic       out_valid,
  output vec_t       out_len,
  output side_t      out_side
);

  logic [DW-1:0] mag_u;
  logic [31:0]   mag_hi, mag_lo;
  logic [63:0]   prod_hi, prod_lo;
  logic [31:0]   azim_sum;
  side_t         side_nxt;

  logic          valid1_r, valid2_r;
  logic [63:0]   prod_hi_r, prod_lo_r;
  side_t         side1_r, side2_r;
  vec_t          len_r;

  always_comb begin
    mag_u    = in_mag[DW-1] ? '0 : in_mag;
    mag_hi   = mag_u[DW-1:32];
    mag_lo   = mag_u[31:0];
    prod_hi  = mag_hi * INV_GAIN;
    prod_lo  = mag_lo * INV_GAIN;
    azim_sum = in_ang[31:0] + ROUND_HALF;
    side_nxt = in_side;
    side_nxt.azim = in_side.tzero ? '0 : azim_sum[31:ROUND_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else if (en) begin
      valid1_r <= in_valid;
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_hi_r <= prod_hi;
      prod_lo_r <= prod_lo;
      side1_r   <= side_nxt;
      len_r     <= vec_t'(prod_hi_r + {32'b0, prod_lo_r[63:32]});
      side2_r   <= side1_r;
    end
  end

  assign out_valid = valid2_r;
  assign out_len   = len_r;
  assign out_side  = side2_r;

endmodule

`default_nettype wire

// ----- hdl/track_direction_angles_core.sv -----
// Top level of the track direction angle pipeline.
//
// Usage: the input channel (in_valid / in_ready) takes one track per transfer:
// a 16-bit tag and the signed x, y, z of its first and fourth hit points.
// The result channel (out_valid / out_ready) returns, per track, the tag, the
// azimuth in [0, 1) turn, the signed polar angle in units of 1/65536 turn and
// a flag that marks a track whose first and fourth points coincide.
// The pipeline has one difference stage, two 31-stage CORDIC pipelines
// (pre-rotation plus 30 iterations each), two gain-correction stages and one
// output stage. Throughput is one track per cycle while the receiver does not
// stall; the 32 x 32 multipliers of the gain stage and the 64-bit add/subtract
// per iteration stage set the clock period.
// Reset clears every valid bit, so the pipeline comes up empty with out_valid
// low. When the receiver stalls, the whole pipeline holds in place and
// in_ready drops in the same cycle; nothing is lost or repeated, and a track
// may still enter while a finished result waits only if the output stage moves.
`default_nettype none

module track_direction_angles_core
  import tda_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [TAG_WIDTH-1:0]          in_track_tag,
  input  wire logic signed [COORD_WIDTH-1:0] in_x_first,
  input  wire logic signed [COORD_WIDTH-1:0] in_y_first,
  input  wire logic signed [COORD_WIDTH-1:0] in_z_first,
  input  wire logic signed [COORD_WIDTH-1:0] in_x_fourth,
  input  wire logic signed [COORD_WIDTH-1:0] in_y_fourth,
  input  wire logic signed [COORD_WIDTH-1:0] in_z_fourth,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [TAG_WIDTH-1:0]               out_result_tag,
  output logic [ANGLE_WIDTH-1:0]             out_azimuth,
  output logic signed [ANGLE_WIDTH-1:0]      out_polar,
  output logic                               out_polar_undefined
);

  // The pipeline advances as one unit whenever the output stage can move.
  logic out_valid_r;
  logic en;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1: point differences, fourth minus first.
  logic                         d_valid_r;
  logic [TAG_WIDTH-1:0]         d_tag_r;
  logic signed [DIFF_WIDTH-1:0] dx_r, dy_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_tag_r <= in_track_tag;
      dx_r    <= DIFF_WIDTH'(in_x_fourth) - DIFF_WIDTH'(in_x_first);
      dy_r    <= DIFF_WIDTH'(in_y_fourth) - DIFF_WIDTH'(in_y_first);
      dz_r    <= DIFF_WIDTH'(in_z_fourth) - DIFF_WIDTH'(in_z_first);
    end
  end

  // First CORDIC: azimuth and transverse magnitude from the scaled dx, dy.
  side_t c1_side;
  vec_t  c1_x_in, c1_y_in;
  always_comb begin
    c1_side.tag   = d_tag_r;
    c1_side.dz    = dz_r;
    c1_side.tzero = (dx_r == '0) && (dy_r == '0);
    c1_side.azim  = '0;
    c1_x_in       = vec_t'(dx_r) <<< GUARD_BITS;
    c1_y_in       = vec_t'(dy_r) <<< GUARD_BITS;
  end

  logic  c1_valid;
  vec_t  c1_mag;
  acc_t  c1_ang;
  side_t c1_side_out;

  tda_cordic u_cordic_phi (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid_r),
    .in_x      (c1_x_in),
    .in_y      (c1_y_in),
    .in_side   (c1_side),
    .out_valid (c1_valid),
    .out_x     (c1_mag),
    .out_ang   (c1_ang),
    .out_side  (c1_side_out)
  );

  // Gain correction turns the CORDIC magnitude into the transverse length.
  logic  g_valid;
  vec_t  g_len;
  side_t g_side;

  tda_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c1_valid),
    .in_mag    (c1_mag),
    .in_ang    (c1_ang),
    .in_side   (c1_side_out),
    .out_valid (g_valid),
    .out_len   (g_len),
    .out_side  (g_side)
  );

  // Second CORDIC: polar angle of (dz, length).
  vec_t c2_x_in;
  assign c2_x_in = vec_t'(g_side.dz) <<< GUARD_BITS;

  logic  c2_valid;
  vec_t  c2_mag;
  acc_t  c2_ang;
  side_t c2_side;

  tda_cordic u_cordic_theta (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (g_valid),
    .in_x      (c2_x_in),
    .in_y      (g_len),
    .in_side   (g_side),
    .out_valid (c2_valid),
    .out_x     (c2_mag),
    .out_ang   (c2_ang),
    .out_side  (c2_side)
  );

  // Final stage: fold a negative dz into the range, round, saturate and
  // apply the coincident-point and zero-dz special cases.
  acc_t                          th_adj, th_rnd;
  logic signed [PF_W-1:0]        pol_full;
  logic signed [ANGLE_WIDTH-1:0] pol_nxt;
  logic                          undef_nxt;
  logic                          unused_mag;

  assign unused_mag = ^c2_mag;

  always_comb begin
    th_adj   = c2_side.dz[DIFF_WIDTH-1] ? c2_ang - HALF_TURN : c2_ang;
    th_rnd   = th_adj + acc_t'(ROUND_HALF);
    pol_full = th_rnd[ACC_W-1:ROUND_SHIFT];
    if (pol_full <= -PF_W'(Q_OUT)) begin
      pol_nxt = ANGLE_WIDTH'(-Q_OUT + 1);
    end else if (pol_full > PF_W'(Q_OUT)) begin
      pol_nxt = ANGLE_WIDTH'(Q_OUT);
    end else begin
      pol_nxt = pol_full[ANGLE_WIDTH-1:0];
    end
    undef_nxt = 1'b0;
    if (c2_side.tzero) begin
      pol_nxt   = '0;
      undef_nxt = (c2_side.dz == '0) && !unused_mag | (c2_side.dz == '0);
    end else if (c2_side.dz == '0) begin
      pol_nxt = ANGLE_WIDTH'(Q_OUT);
    end
  end

  logic [TAG_WIDTH-1:0]          out_tag_r;
  logic [ANGLE_WIDTH-1:0]        out_azim_r;
  logic signed [ANGLE_WIDTH-1:0] out_pol_r;
  logic                          out_undef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag_r   <= c2_side.tag;
      out_azim_r  <= c2_side.azim;
      out_pol_r   <= pol_nxt;
      out_undef_r <= undef_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_tag      = out_tag_r;
  assign out_azimuth         = out_azim_r;
  assign out_polar           = out_pol_r;
  assign out_polar_undefined = out_undef_r;

  // A track with coincident points reports both angles as zero.
  a_undef_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_undef_r |-> out_pol_r == '0 && out_azim_r == '0)
    else $error("undefined polar with nonzero angles");

  // The polar angle always lies in (-1/4, 1/4] turn.
  a_polar_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pol_r <= ANGLE_WIDTH'(Q_OUT) && out_pol_r > -ANGLE_WIDTH'(Q_OUT))
    else $error("polar angle out of range");

  // The input side only stalls while a result waits on the receiver.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r && !out_ready)
    else $error("input stalled without an output stall");

endmodule

`default_nettype wire

// ----- dv/track_direction_angles_checker.sv -----
// Checker for the track direction angle pipeline: computes expected angles and compares them.
`timescale 1ns / 1ps
`default_nettype none

module track_direction_angles_checker
  import tda_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic [TAG_WIDTH-1:0]          in_track_tag,
  input  wire logic signed [COORD_WIDTH-1:0] in_x_first,
  input  wire logic signed [COORD_WIDTH-1:0] in_y_first,
  input  wire logic signed [COORD_WIDTH-1:0] in_z_first,
  input  wire logic signed [COORD_WIDTH-1:0] in_x_fourth,
  input  wire logic signed [COORD_WIDTH-1:0] in_y_fourth,
  input  wire logic signed [COORD_WIDTH-1:0] in_z_fourth,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [TAG_WIDTH-1:0]          out_result_tag,
  input  wire logic [ANGLE_WIDTH-1:0]        out_azimuth,
  input  wire logic signed [ANGLE_WIDTH-1:0] out_polar,
  input  wire logic                          out_polar_undefined,
  output int                                 fail_count,
  output int                                 pending_count
);

  typedef struct packed {
    logic [TAG_WIDTH-1:0]          tag;
    logic [ANGLE_WIDTH-1:0]        azim;
    logic signed [ANGLE_WIDTH-1:0] polar;
    logic                          undef;
  } angles_t;

  angles_t expected_angles[$];

  localparam longint QTURN = 64'sd1 << 30;
  localparam longint HTURN = 64'sd1 << 31;

  function automatic longint arctan_turns(input int i);
    longint tbl[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
      20, 10, 5, 3, 1};
    return tbl[i];
  endfunction

  // Vectoring CORDIC; >>> on signed longint rounds toward minus infinity.
  function automatic longint vector_angle(input longint vx, input longint vy,
                                          output longint mag);
    longint a, t, xs, ys;
    a = 0;
    if (vx < 0) begin
      if (vy >= 0) begin
        t = vx; vx = vy; vy = -t; a = QTURN;
      end else begin
        t = vx; vx = -vy; vy = t; a = -QTURN;
      end
    end
    for (int i = 0; i < 30; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx = vx + ys; vy = vy - xs; a += arctan_turns(i);
      end else begin
        vx = vx - ys; vy = vy + xs; a -= arctan_turns(i);
      end
    end
    mag = vx;
    return a;
  endfunction

  function automatic angles_t track_angles(input logic [TAG_WIDTH-1:0] tag,
      input longint dx, input longint dy, input longint dz);
    angles_t r;
    longint mag, dm, phi, th, len, pol;
    longint unsigned u, pu;
    longint qo;
    qo = 1 << (ANGLE_WIDTH - 2);
    r = '0;
    r.tag = tag;
    if (dx == 0 && dy == 0) begin
      r.undef = (dz == 0);
    end else begin
      phi = vector_angle(dx <<< GUARD_BITS, dy <<< GUARD_BITS, mag);
      pu = longint'(phi) & 64'hFFFF_FFFF;
      r.azim = ANGLE_WIDTH'((pu + (64'd1 << (31 - ANGLE_WIDTH))) >> (32 - ANGLE_WIDTH));
      if (dz == 0) begin
        pol = qo;
      end else begin
        u = (mag > 0) ? mag : 0;
        len = (u >> 32) * INV_GAIN + (((u & 64'hFFFF_FFFF) * INV_GAIN) >> 32);
        th = vector_angle(dz <<< GUARD_BITS, len, dm);
        if (dz < 0) th -= HTURN;
        pol = (th + (64'sd1 <<< (31 - ANGLE_WIDTH))) >>> (32 - ANGLE_WIDTH);
        if (pol <= -qo) pol = -qo + 1;
        if (pol > qo) pol = qo;
      end
      r.polar = ANGLE_WIDTH'(pol);
    end
    return r;
  endfunction

  angles_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_angles.push_back(track_angles(in_track_tag,
          longint'(in_x_fourth) - longint'(in_x_first),
          longint'(in_y_fourth) - longint'(in_y_first),
          longint'(in_z_fourth) - longint'(in_z_first)));
      if (out_valid && out_ready) begin
        got = '{out_result_tag, out_azimuth, out_polar, out_polar_undefined};
        if (expected_angles.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result transfer: %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_angles.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"Mismatch: expected tag %h azim %0d polar %0d undef %b,",
                        " got tag %h azim %0d polar %0d undef %b"},
                want.tag, want.azim, want.polar, want.undef,
                got.tag, got.azim, got.polar, got.undef);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending_count = expected_angles.size();

endmodule

`default_nettype wire

// ----- dv/track_direction_angles_core_tb.sv -----
// Testbench top for the track direction angle pipeline: stimulus, idling and verdict.
`timescale 1ns / 1ps
`default_nettype none

module track_direction_angles_core_tb;
  import tda_pkg::*;

  localparam int LATENCY      = 66;
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_OFF_LEN = 200;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [TAG_WIDTH-1:0] in_track_tag;
  logic signed [COORD_WIDTH-1:0] in_x_first, in_y_first, in_z_first;
  logic signed [COORD_WIDTH-1:0] in_x_fourth, in_y_fourth, in_z_fourth;
  logic [TAG_WIDTH-1:0] out_result_tag;
  logic [ANGLE_WIDTH-1:0] out_azimuth;
  logic signed [ANGLE_WIDTH-1:0] out_polar;
  logic out_polar_undefined;
  int fail_count, pending_count;

  // Idling percentages for the sender and the receiver; the receiver side
  // also has a forced hold-off used to fill the pipeline.
  int send_idle_pct, recv_stall_pct;
  logic hold_off_req;
  logic hold_off_done;
  int hold_off_cycles;
  int quiet_cycles;

  track_direction_angles_core u_dut (.*);

  track_direction_angles_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver draws its ready each cycle. Once a hold-off is requested,
  // ready stays low for a counted stretch regardless of the stall percentage.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready       <= 1'b0;
      hold_off_cycles <= 0;
      hold_off_done   <= 1'b0;
    end else if (hold_off_req && !hold_off_done) begin
      hold_off_done   <= 1'b1;
      hold_off_cycles <= HOLD_OFF_LEN;
      out_ready       <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The watchdog ends the run if no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Watchdog timeout with %0d results outstanding", pending_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Random coordinate: mostly full-range random numbers, some at the extremes,
  // and some small values so that small or zero differences are common.
  function automatic logic [COORD_WIDTH-1:0] pick_coord();
    case ($urandom_range(5))
      0: return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      1: return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      2: return COORD_WIDTH'($urandom_range(15) - 8);
      default: return COORD_WIDTH'($urandom);
    endcase
  endfunction

  // Present one track and hold it until the transfer completes.
  task automatic send_track(input logic [TAG_WIDTH-1:0] tag,
      input logic [COORD_WIDTH-1:0] xa, ya, za, xb, yb, zb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_track_tag <= tag;
    in_x_first   <= xa;
    in_y_first   <= ya;
    in_z_first   <= za;
    in_x_fourth  <= xb;
    in_y_fourth  <= yb;
    in_z_fourth  <= zb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random_track();
    logic [COORD_WIDTH-1:0] xa, ya, za, xb, yb, zb;
    xa = pick_coord(); ya = pick_coord(); za = pick_coord();
    xb = pick_coord(); yb = pick_coord(); zb = pick_coord();
    // Sometimes reuse the first point's coordinates for the fourth point.
    case ($urandom_range(7))
      0: begin xb = xa; yb = ya; end
      1: zb = za;
      2: begin xb = xa; yb = ya; zb = za; end
      3: xb = xa + COORD_WIDTH'($urandom_range(4) - 2);
      default: ;
    endcase
    send_track(TAG_WIDTH'($urandom), xa, ya, za, xb, yb, zb);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  int done_wait;

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_track_tag = '0;
    {in_x_first, in_y_first, in_z_first} = '0;
    {in_x_fourth, in_y_fourth, in_z_fourth} = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed tracks: coincident points, zero transverse or z difference,
    // the four axis directions, the largest differences and a near-wrap
    // azimuth just below a full turn.
    send_track(16'h0000, '0, '0, '0, '0, '0, '0);
    send_track(16'hFFFF, 24'd5, 24'd5, 24'd5, 24'd5, 24'd5, 24'd9);
    send_track(16'h0001, 24'd5, 24'd5, 24'd5, 24'd5, 24'd5, -24'sd9);
    send_track(16'h0002, '0, '0, '0, 24'd10, '0, '0);
    send_track(16'h0003, '0, '0, '0, -24'sd10, '0, '0);
    send_track(16'h0004, '0, '0, '0, '0, 24'd10, '0);
    send_track(16'h0005, '0, '0, '0, '0, -24'sd10, '0);
    send_track(16'h0006, '0, '0, '0, -24'sd10, -24'sd10, 24'd7);
    send_track(16'h0007, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send_track(16'h0008, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    send_track(16'h0009, CMAX, CMIN, '0, CMIN, CMAX, '0);
    send_track(16'h000A, '0, '0, '0, CMAX, '1, 24'd1);
    send_track(16'h000B, '0, '0, '0, 24'd1, '0, CMAX);
    send_track(16'h000C, '0, '0, '0, 24'd1, '0, CMIN);
    send_track(16'h000D, '0, '0, CMAX, CMAX, '0, CMIN);
    send_track(16'h000E, '0, '0, '0, '0, 24'd1, '1);
    send_track(16'hA5A5, 24'h555555, 24'hAAAAAA, 24'h123456,
               24'hAAAAAA, 24'h555555, 24'hEDCBA9);
    drain_results();

    // Random phases with differing idling on each side.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        3: begin send_idle_pct = 15; recv_stall_pct = 15; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // In the last phase the receiver holds off long enough that the
      // pipeline fills and the input channel must stall.
      if (phase == 4) hold_off_req <= 1'b1;
      for (int n = 0; n < 130; n++) send_random_track();
      // After phase 2 the sender pauses until every expected result has come back.
      if (phase == 2) drain_results();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    done_wait = 0;
    while (pending_count != 0 && done_wait < IDLE_LIMIT) begin
      @(posedge clk);
      done_wait++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
